FILE: src/m2l_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package m2l_pkg;

    // Number of far cells in one walk.
    localparam logic [7:0] WALK_LENGTH = 8'd189;
    // Geometry of the 7x7x7 vector cube.
    localparam logic [8:0] CUBE_SIDE   = 9'd7;
    localparam logic [8:0] PLANE_CELLS = 9'd49;
    // Last coordinate of the 6x6x6 neighbor region.
    localparam logic [2:0] REGION_LAST = 3'd5;

    // Configuration register index (taken from paddr[2]).
    localparam logic REG_BLOCK_SIDE = 1'b0;
    localparam logic [2:0] BLOCK_SIDE_RESET = 3'd2;

    // Walk context kept in the context memory.
    typedef struct packed {
        logic [2:0]  sibling;
        logic [2:0]  fx;
        logic [2:0]  fy;
        logic [2:0]  fz;
        logic [10:0] prev_src;
        logic [8:0]  prev_ker;
        logic [7:0]  count;
        logic        done;
    } ctx_t;

    localparam ctx_t CTX_RESET = '{
        sibling:  3'd0,
        fx:       3'd0,
        fy:       3'd0,
        fz:       3'd0,
        prev_src: 11'd0,
        prev_ker: 9'd0,
        count:    8'd0,
        done:     1'b1
    };

    // Request to the offset unit for one far cell.
    typedef struct packed {
        logic [2:0] sib;
        logic [1:0] hx;
        logic [1:0] hy;
        logic [1:0] hz;
        logic [2:0] dim;
        logic [2:0] ux;
        logic [2:0] uy;
        logic [2:0] uz;
    } off_req_t;

endpackage

`default_nettype wire

FILE: src/m2l_interaction_offset_walker_core.sv
`timescale 1ns / 1ps
`default_nettype none

// M2L interaction-list offset walker.
// Each input transfer (sibling, restart) requests the next far-field interaction of
// the current walk; restart = 1 latches the sibling and begins a new walk of 189
// interactions. Every input transfer produces exactly one output transfer carrying
// the absolute source and kernel offsets, their changes from the previous
// interaction, the step number and a last flag, or exhausted = 1 with all other
// fields zero when no walk is active.
// The walk context lives in a one-entry synchronous context memory that is read
// when an item is taken and written back when its result enters the output register.
// An interaction passes through the context read, a scan of the visited region
// cells (up to four cells per item), the offset multiply chain and the result
// register; an exhausted result for a walk that is already done goes from the
// context read straight to the result register. The block works on one item at a
// time: it takes a new item only once the last result has entered the output register.
// block_side is written over the APB-style port at byte address 0; it resets to 2.
// Reset clears the control logic and marks the context memory entry invalid, so the
// first request without restart reports exhausted.
// While the receiver stalls, the output register holds its result; one more item
// may be taken and finishes its work, then waits until the output register frees.

module m2l_interaction_offset_walker_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  sibling,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [10:0]      source_offset,
    output logic [8:0]       kernel_offset,
    output logic [11:0]      source_delta,
    output logic [9:0]       kernel_delta,
    output logic [7:0]       step_number,
    output logic             last,
    output logic             exhausted
);
    import m2l_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_MUL,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [10:0] src;
        logic [8:0]  ker;
        logic [11:0] sd;
        logic [9:0]  kd;
        logic [7:0]  step;
        logic        last;
        logic        exh;
    } res_t;

    localparam res_t RES_EXHAUSTED = '{
        src: 11'd0, ker: 9'd0, sd: 12'd0, kd: 10'd0, step: 8'd0, last: 1'b0, exh: 1'b1
    };

    state_t state_reg, state_next;
    ctx_t   work_reg, work_next;
    res_t   pend_reg, pend_next;
    res_t   out_reg, out_next;
    logic   out_valid_reg, out_valid_next;
    logic   restart_q_reg, restart_q_next;
    logic [2:0] sibling_q_reg, sibling_q_next;
    logic [2:0] block_side_reg, block_side_next;

    logic     in_take;
    logic     slot_free;
    logic     cfg_write;
    logic     ram_wr;
    ctx_t     ram_rd_data;
    ctx_t     ctx_start;
    logic     off_start;
    off_req_t off_req;
    logic [10:0] off_src;
    logic [8:0]  off_ker;
    logic        off_done;

    logic [2:0] side_sat;
    logic [2:0] ux, uy, uz;
    logic       cell_near;
    logic       at_end;
    logic [2:0] nfx, nfy, nfz;

    assign in_take   = in_valid && (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BLOCK_SIDE);
    assign ram_wr    = (state_reg == S_FINISH) && slot_free;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BLOCK_SIDE) ? {29'd0, block_side_reg} : 32'd0;

    m2l_ctx_ram u_ctx_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_take),
        .wr_en   (ram_wr),
        .wr_data (work_reg),
        .rd_data (ram_rd_data)
    );

    m2l_offset_unit u_offset (
        .clk   (clk),
        .rst_n (rst_n),
        .start (off_start),
        .req   (off_req),
        .src   (off_src),
        .ker   (off_ker),
        .done  (off_done)
    );

    // Geometry of the cell under the scan position.
    always_comb
    begin
        if (block_side_reg == 3'd0)
        begin
            side_sat = 3'd1;
        end
        else if (block_side_reg > 3'd4)
        begin
            side_sat = 3'd4;
        end
        else
        begin
            side_sat = block_side_reg;
        end

        ux = work_reg.fx + 3'd1 - {2'b00, work_reg.sibling[2]};
        uy = work_reg.fy + 3'd1 - {2'b00, work_reg.sibling[1]};
        uz = work_reg.fz + 3'd1 - {2'b00, work_reg.sibling[0]};
        cell_near = (ux >= 3'd2) && (ux <= 3'd4) && (uy >= 3'd2) && (uy <= 3'd4)
                 && (uz >= 3'd2) && (uz <= 3'd4);

        // Next position in the region, x fastest.
        at_end = (work_reg.fx == REGION_LAST) && (work_reg.fy == REGION_LAST)
              && (work_reg.fz == REGION_LAST);
        nfx = work_reg.fx;
        nfy = work_reg.fy;
        nfz = work_reg.fz;
        if (work_reg.fx != REGION_LAST)
        begin
            nfx = work_reg.fx + 3'd1;
        end
        else
        begin
            nfx = 3'd0;
            if (work_reg.fy != REGION_LAST)
            begin
                nfy = work_reg.fy + 3'd1;
            end
            else
            begin
                nfy = 3'd0;
                nfz = (work_reg.fz != REGION_LAST) ? work_reg.fz + 3'd1 : 3'd0;
            end
        end

        off_req.sib = {work_reg.fx[0], work_reg.fy[0], work_reg.fz[0]};
        off_req.hx  = work_reg.fx[2:1];
        off_req.hy  = work_reg.fy[2:1];
        off_req.hz  = work_reg.fz[2:1];
        off_req.dim = side_sat + 3'd2;
        off_req.ux  = ux;
        off_req.uy  = uy;
        off_req.uz  = uz;

        // A restart begins from a cleared context with the new sibling.
        if (restart_q_reg)
        begin
            ctx_start = CTX_RESET;
            ctx_start.sibling = sibling_q_reg;
            ctx_start.done = 1'b0;
        end
        else
        begin
            ctx_start = ram_rd_data;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        work_next       = work_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        restart_q_next  = restart_q_reg;
        sibling_q_next  = sibling_q_reg;
        block_side_next = block_side_reg;
        off_start       = 1'b0;

        if (cfg_write)
        begin
            block_side_next = pwdata[2:0];
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    restart_q_next = restart;
                    sibling_q_next = sibling;
                    state_next     = S_LOAD;
                end
            end
            S_LOAD:
            begin
                work_next = ctx_start;
                if (ctx_start.done)
                begin
                    pend_next  = RES_EXHAUSTED;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                work_next.fx = nfx;
                work_next.fy = nfy;
                work_next.fz = nfz;
                if (!cell_near)
                begin
                    off_start  = 1'b1;
                    state_next = S_MUL;
                end
                else if (at_end)
                begin
                    // Region ran out before another far cell: the walk ends.
                    work_next.done = 1'b1;
                    pend_next      = RES_EXHAUSTED;
                    state_next     = S_FINISH;
                end
            end
            S_MUL:
            begin
                if (off_done)
                begin
                    pend_next.src  = off_src;
                    pend_next.ker  = off_ker;
                    pend_next.sd   = {1'b0, off_src} - {1'b0, work_reg.prev_src};
                    pend_next.kd   = {1'b0, off_ker} - {1'b0, work_reg.prev_ker};
                    pend_next.step = work_reg.count;
                    pend_next.last = (work_reg.count >= WALK_LENGTH - 8'd1);
                    pend_next.exh  = 1'b0;
                    work_next.prev_src = off_src;
                    work_next.prev_ker = off_ker;
                    work_next.count    = work_reg.count + 8'd1;
                    work_next.done     = (work_reg.count >= WALK_LENGTH - 8'd1);
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            restart_q_reg  <= 1'b0;
            block_side_reg <= BLOCK_SIDE_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            restart_q_reg  <= restart_q_next;
            block_side_reg <= block_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        sibling_q_reg <= sibling_q_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign source_offset = out_reg.src;
    assign kernel_offset = out_reg.ker;
    assign source_delta  = out_reg.sd;
    assign kernel_delta  = out_reg.kd;
    assign step_number   = out_reg.step;
    assign last          = out_reg.last;
    assign exhausted     = out_reg.exh;

endmodule

`default_nettype wire

FILE: src/m2l_ctx_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module m2l_ctx_ram (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         rd_en,
    input  wire logic         wr_en,
    input  wire m2l_pkg::ctx_t wr_data,
    output m2l_pkg::ctx_t     rd_data
);
    import m2l_pkg::*;

    ctx_t ctx_mem [1];
    ctx_t rd_data_reg;
    logic entry_valid_reg;
    logic rd_valid_reg;

    // The entry has no reset; a valid bit makes an unwritten entry read as the reset context.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_valid_reg <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= entry_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ctx_mem[0] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ctx_mem[0];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : CTX_RESET;

endmodule

`default_nettype wire

FILE: src/m2l_offset_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module m2l_offset_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire m2l_pkg::off_req_t req,
    output logic [10:0]          src,
    output logic [8:0]           ker,
    output logic                 done
);
    import m2l_pkg::*;

    // Near cells of the cube have every shifted component in 2..4.
    function automatic logic [1:0] clamp_near(input logic [2:0] u);
        logic [1:0] r;
        if (u < 3'd2)
        begin
            r = 2'd0;
        end
        else if (u > 3'd4)
        begin
            r = 2'd3;
        end
        else
        begin
            r = 2'(u - 3'd2);
        end
        return r;
    endfunction

    function automatic logic in_near(input logic [2:0] u);
        return (u >= 3'd2) && (u <= 3'd4);
    endfunction

    logic v1_reg, v2_reg, v3_reg;
    logic [5:0]  t1_reg;
    logic [8:0]  t2_reg;
    logic [10:0] src_reg;
    logic [8:0]  ker_reg;
    logic [2:0]  dim1_reg, dim2_reg;
    logic [1:0]  hy1_reg, hx1_reg, hx2_reg;

    logic [8:0] cube_index;
    logic [8:0] near_below;
    logic [8:0] row_part;

    always_comb
    begin
        cube_index = 9'(req.ux) + 9'(req.uy) * CUBE_SIDE + 9'(req.uz) * PLANE_CELLS;
        row_part = 9'd0;
        if (in_near(req.uz))
        begin
            row_part = 9'(clamp_near(req.uy)) * 9'd3;
            if (in_near(req.uy))
            begin
                row_part = row_part + 9'(clamp_near(req.ux));
            end
        end
        near_below = 9'(clamp_near(req.uz)) * 9'd9 + row_part;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Horner chain ((sib*D + hz)*D + hy)*D + hx, one multiply per stage.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            t1_reg   <= 6'(6'(req.sib) * 6'(req.dim) + 6'(req.hz));
            ker_reg  <= cube_index - near_below;
            dim1_reg <= req.dim;
            hy1_reg  <= req.hy;
            hx1_reg  <= req.hx;
        end
        if (v1_reg)
        begin
            t2_reg   <= 9'(9'(t1_reg) * 9'(dim1_reg) + 9'(hy1_reg));
            dim2_reg <= dim1_reg;
            hx2_reg  <= hx1_reg;
        end
        if (v2_reg)
        begin
            src_reg <= 11'(11'(t2_reg) * 11'(dim2_reg) + 11'(hx2_reg));
        end
    end

    assign src  = src_reg;
    assign ker  = ker_reg;
    assign done = v3_reg;

endmodule

`default_nettype wire

FILE: src/m2l_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module m2l_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [10:0] source_offset,
    input wire logic [8:0]  kernel_offset,
    input wire logic [11:0] source_delta,
    input wire logic [9:0]  kernel_delta,
    input wire logic [7:0]  step_number,
    input wire logic        last,
    input wire logic        exhausted
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(source_offset)
            && $stable(kernel_offset) && $stable(step_number) && $stable(exhausted))
        else $error("stalled result changed");

    // One item at a time: a transfer in closes the input until its result is done.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a transfer");

    a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exhausted |-> source_offset == 11'd0 && kernel_offset == 9'd0
            && source_delta == 12'd0 && kernel_delta == 10'd0
            && step_number == 8'd0 && !last)
        else $error("exhausted result carries data");

    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> step_number == 8'd188 && !exhausted)
        else $error("last flag on wrong step");

    // The first interaction of a walk is measured against zero.
    a_first_delta: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !exhausted && step_number == 8'd0 |->
            source_delta == {1'b0, source_offset} && kernel_delta == {1'b0, kernel_offset})
        else $error("first delta differs from offset");

endmodule

bind m2l_interaction_offset_walker_core m2l_checker u_m2l_checker (.*);

`default_nettype wire

FILE: tb/tb_m2l_interaction_offset_walker_core.sv
`timescale 1ns / 1ps

module tb_m2l_interaction_offset_walker_core;
    import m2l_pkg::*;

    // Geometry of the walk as seen from outside the block.
    localparam int REGION_SIDE  = 6;
    localparam int REGION_CELLS = 216;
    localparam int VECTOR_SIDE  = 7;
    localparam int VECTOR_PLANE = 49;
    localparam int VECTOR_CELLS = 343;

    // Timing of the run.
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 24;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 100;
    localparam int PRINT_LIMIT    = 40;

    // One request to the walker.
    typedef struct packed {
        logic [2:0] sibling;
        logic       restart;
    } request_t;

    // One interaction as the walker reports it.
    typedef struct packed {
        logic [10:0] source_offset;
        logic [8:0]  kernel_offset;
        logic [11:0] source_delta;
        logic [9:0]  kernel_delta;
        logic [7:0]  step_number;
        logic        last;
        logic        exhausted;
    } interaction_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  sibling = '0;
    logic        restart = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [10:0] source_offset;
    logic [8:0]  kernel_offset;
    logic [11:0] source_delta;
    logic [9:0]  kernel_delta;
    logic [7:0]  step_number;
    logic        last;
    logic        exhausted;

    m2l_interaction_offset_walker_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sibling       (sibling),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .source_offset (source_offset),
        .kernel_offset (kernel_offset),
        .source_delta  (source_delta),
        .kernel_delta  (kernel_delta),
        .step_number   (step_number),
        .last          (last),
        .exhausted     (exhausted)
    );

    always #4 clk = ~clk;

    // Requests waiting to be offered, and interactions predicted but not yet seen.
    request_t     request_queue[$];
    interaction_t interaction_queue[$];

    // Mirror of the walker state. It starts from the reset values and only the
    // accepted input transfers and register writes move it.
    logic [2:0]  shadow_block_side = BLOCK_SIDE_RESET;
    logic [2:0]  shadow_sibling = '0;
    int          shadow_position = 0;
    logic [10:0] shadow_prev_source = '0;
    logic [8:0]  shadow_prev_kernel = '0;
    int          shadow_count = 0;
    logic        shadow_done = 1'b1;

    // Rank of every cell of the 7x7x7 vector cube among the far cells.
    int far_rank_of[0:VECTOR_CELLS-1];

    int  error_count = 0;
    bit  bursts_enabled = 1'b0;
    int  holds_requested = 0;
    int  holds_served = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    int  walk_left = 0;
    request_t next_request;

    // A shifted vector component 0..6 is near when the raw component is -1..1.
    function automatic bit shifted_near(input int u);
        return (u >= 2) && (u <= 4);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < PRINT_LIMIT)
            $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Advance the walk by one request and queue the interaction it must produce.
    function automatic void predict_interaction(input logic [2:0] sib, input logic rst);
        interaction_t r;
        int lx, ly, lz, b, d, p, fx, fy, fz, ux, uy, uz, src_sib, src, ker;
        bit found;
        r = '0;
        found = 1'b0;
        if (rst) begin
            shadow_sibling     = sib;
            shadow_position    = 0;
            shadow_prev_source = '0;
            shadow_prev_kernel = '0;
            shadow_count       = 0;
            shadow_done        = 1'b0;
        end
        if (shadow_done) begin
            r.exhausted = 1'b1;
            interaction_queue.push_back(r);
            return;
        end
        lx = int'(shadow_sibling[2]);
        ly = int'(shadow_sibling[1]);
        lz = int'(shadow_sibling[0]);
        // Out-of-range block sides saturate into 1..4.
        b = int'(shadow_block_side);
        if (b < 1) b = 1;
        if (b > 4) b = 4;
        d = b + 2;
        for (p = shadow_position; p < REGION_CELLS && !found; p++) begin
            fx = p % REGION_SIDE;
            fy = (p / REGION_SIDE) % REGION_SIDE;
            fz = p / (REGION_SIDE * REGION_SIDE);
            ux = fx + 1 - lx;
            uy = fy + 1 - ly;
            uz = fz + 1 - lz;
            if (!(shifted_near(ux) && shifted_near(uy) && shifted_near(uz))) begin
                found = 1'b1;
                src_sib = 4 * (fx % 2) + 2 * (fy % 2) + (fz % 2);
                src = ((src_sib * d + fz / 2) * d + fy / 2) * d + fx / 2;
                ker = far_rank_of[ux + VECTOR_SIDE * uy + VECTOR_PLANE * uz];
                r.source_offset = 11'(src);
                r.kernel_offset = 9'(ker);
                r.source_delta  = 12'(src - int'(shadow_prev_source));
                r.kernel_delta  = 10'(ker - int'(shadow_prev_kernel));
                r.step_number   = 8'(shadow_count);
                r.last          = (shadow_count + 1 >= int'(WALK_LENGTH));
                shadow_prev_source = 11'(src);
                shadow_prev_kernel = 9'(ker);
                shadow_position    = p + 1;
                shadow_count++;
                if (shadow_count >= int'(WALK_LENGTH)) shadow_done = 1'b1;
            end
        end
        if (!found) begin
            // The region ran out of far cells, which ends the walk.
            shadow_position = REGION_CELLS;
            shadow_done     = 1'b1;
            r.exhausted     = 1'b1;
        end
        interaction_queue.push_back(r);
    endfunction

    // Sender. An offered request stays on the bus until it is taken; gaps are only
    // inserted between transfers, never while a request is pending.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            sibling  <= '0;
            restart  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && !in_stall)
                predict_interaction(sibling, restart);
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (bursts_enabled && $urandom_range(0, 9) == 0) begin
                    // A random gap starts here.
                    in_valid <= 1'b0;
                    send_gap <= $urandom_range(0, 16);
                end else if (request_queue.size() != 0) begin
                    next_request = request_queue.pop_front();
                    in_valid <= 1'b1;
                    sibling  <= next_request.sibling;
                    restart  <= next_request.restart;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Every output transfer is checked against the oldest prediction.
    // The stall pattern is random bursts, plus long holds that fill the block up.
    task automatic check_interaction();
        interaction_t want;
        if (interaction_queue.size() == 0) begin
            report_mismatch("unexpected output transfer", 1, 0);
            return;
        end
        want = interaction_queue.pop_front();
        if (source_offset !== want.source_offset)
            report_mismatch("source_offset", int'(source_offset), int'(want.source_offset));
        if (kernel_offset !== want.kernel_offset)
            report_mismatch("kernel_offset", int'(kernel_offset), int'(want.kernel_offset));
        if (source_delta !== want.source_delta)
            report_mismatch("source_delta", int'($signed(source_delta)),
                            int'($signed(want.source_delta)));
        if (kernel_delta !== want.kernel_delta)
            report_mismatch("kernel_delta", int'($signed(kernel_delta)),
                            int'($signed(want.kernel_delta)));
        if (step_number !== want.step_number)
            report_mismatch("step_number", int'(step_number), int'(want.step_number));
        if (last !== want.last)
            report_mismatch("last", int'(last), int'(want.last));
        if (exhausted !== want.exhausted)
            report_mismatch("exhausted", int'(exhausted), int'(want.exhausted));
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && !out_stall)
                check_interaction();
            if (stall_left > 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (holds_served != holds_requested) begin
                holds_served <= holds_served + 1;
                out_stall    <= 1'b1;
                stall_left   <= LONG_HOLD - 1;
            end else if (bursts_enabled && $urandom_range(0, 9) == 0) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 16);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog. It counts cycles without any transfer while work is outstanding.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (request_queue.size() != 0 || in_valid || interaction_queue.size() != 0) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end else begin
            quiet_cycles <= 0;
        end
    end

    // Register writes go through a setup and an access phase while the block is idle.
    task automatic write_block_side(input logic [2:0] value);
        logic [31:0] word;
        word = $urandom;
        word[2:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BLOCK_SIDE, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_block_side = value;
    endtask

    // Wait until every request has been taken and every interaction has come back,
    // then give the block time to fall quiet.
    task automatic drain_walker();
        while (request_queue.size() != 0 || in_valid || interaction_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic push_request(input logic [2:0] sib, input logic rst);
        request_t r;
        r.sibling = sib;
        r.restart = rst;
        request_queue.push_back(r);
    endtask

    // Random requests: mostly whole or partial walks with random siblings, some of
    // them run past their end, with stray requests and early restarts mixed in.
    task automatic queue_random_requests(input int count);
        request_t r;
        repeat (count) begin
            r.sibling = 3'($urandom_range(0, 7));
            r.restart = 1'b0;
            if (walk_left == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    r.restart = 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        walk_left = int'(WALK_LENGTH) - 1 + int'($urandom_range(0, 3));
                    else
                        walk_left = int'($urandom_range(0, 40));
                end else begin
                    r.restart = 1'($urandom_range(0, 1));
                end
            end else begin
                walk_left--;
                if ($urandom_range(0, 49) == 0) r.restart = 1'b1;
            end
            request_queue.push_back(r);
        end
    endtask

    logic [2:0] side_plan[0:7] = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd5, 3'd2, 3'd6};

    initial begin
        int c, rank;
        rank = 0;
        for (c = 0; c < VECTOR_CELLS; c++) begin
            far_rank_of[c] = rank;
            if (!(shifted_near(c % VECTOR_SIDE) && shifted_near((c / VECTOR_SIDE) % VECTOR_SIDE)
                  && shifted_near(c / VECTOR_PLANE)))
                rank++;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset block side. Requests before any restart must
        // come back exhausted; then short walks from the corner siblings, a restart
        // in the middle of a walk, and a first step from every other sibling.
        push_request(3'd5, 1'b0);
        push_request(3'd2, 1'b0);
        push_request(3'd0, 1'b1);
        push_request(3'd7, 1'b0);
        push_request(3'd0, 1'b0);
        push_request(3'd3, 1'b0);
        push_request(3'd7, 1'b1);
        push_request(3'd0, 1'b0);
        push_request(3'd7, 1'b0);
        push_request(3'd1, 1'b1);
        push_request(3'd2, 1'b1);
        push_request(3'd3, 1'b1);
        push_request(3'd4, 1'b1);
        push_request(3'd5, 1'b1);
        push_request(3'd6, 1'b1);
        push_request(3'd0, 1'b0);
        push_request(3'd4, 1'b0);
        drain_walker();

        // Random phases, each at its own block side. Walks carry over from one phase
        // to the next, so the side also changes in the middle of a walk. One phase
        // holds the receiver off for a long stretch while requests keep coming, and two
        // of them, the fifth and the last, run without random gaps or stalls.
        foreach (side_plan[i]) begin
            write_block_side(side_plan[i]);
            @(negedge clk);
            bursts_enabled = (i != 4) && (i != 7);
            if (i == 1) holds_requested++;
            queue_random_requests(PHASE_ITEMS);
            drain_walker();
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
src/m2l_pkg.sv
src/m2l_ctx_ram.sv
src/m2l_offset_unit.sv
src/m2l_interaction_offset_walker_core.sv
src/m2l_checker.sv
tb/tb_m2l_interaction_offset_walker_core.sv
